>>> rtl/ccbd_pkg.sv
// ----------------------------------------------------------------------------
// ccbd_pkg
// Shared widths, memory map constants and types for the CPU bus decoder.
// ----------------------------------------------------------------------------
package ccbd_pkg;

    // Storage sizes
    localparam int RAM_DEPTH = 2048;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int IO_DEPTH  = 32;
    localparam int IO_AW     = $clog2(IO_DEPTH);

    // Memory map
    localparam logic [15:0] ADDR_PAD      = 16'h4016;
    localparam logic [15:0] ADDR_DMA      = 16'h4014;
    localparam logic [10:0] IO_PAGE       = 11'h200;   // 0x4000 >> 5
    localparam logic [7:0]  PAD_OPEN_BUS  = 8'h40;
    localparam logic [9:0]  DMA_STALL     = 10'd513;

    // Word widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Result routing
    typedef enum logic [1:0] {
        ROUTE_LOCAL = 2'd0,
        ROUTE_GFX   = 2'd1,
        ROUTE_ROM   = 2'd2
    } t_route;

    // Work RAM access request
    typedef struct packed {
        logic              en;
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

endpackage

>>> rtl/ccbd_work_ram.sv
// ----------------------------------------------------------------------------
// ccbd_work_ram
// 2 KB work RAM, one synchronous port, registered read data. Sweeps the whole
// array to zero after reset and reports ready once the sweep is done.
// ----------------------------------------------------------------------------
module ccbd_work_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ccbd_pkg::t_ram_req          i_req,
    output logic [7:0]                  o_rdata,
    output logic                        o_ready
);
    import ccbd_pkg::*;

    logic [7:0]        r_mem [RAM_DEPTH];
    logic [7:0]        r_q;
    logic              r_clr;
    logic [RAM_AW-1:0] r_clr_addr;

    // Clearing pass control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // Memory array: clear sweep has priority, requests only come when ready
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.en && i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // Registered read; holds until the next read
    always_ff @(posedge i_clk) begin
        if (!r_clr && i_req.en && !i_req.we) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_q;
    assign o_ready = !r_clr;

endmodule

>>> rtl/console_cpu_bus_decoder.sv
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder
// CPU bus decoder for a fixed-cartridge console memory map.
// ----------------------------------------------------------------------------
// Takes one CPU bus access per word and returns one result word per access.
// Sustained rate is one access per clock while the output is not held off.
// Each result word passes through stage 1 and then the output register. At
// acceptance the access moves into stage 1, and the work RAM read is issued on
// the same edge. The result moves from stage 1 into the output register once
// that register has room. After reset the work RAM is swept to zero, and no
// access is accepted until the sweep is done. Work RAM is mirrored below
// 0x2000, graphics registers (0x2000-0x3FFF) are forwarded as a register
// number, 0x4000-0x401F are local I/O registers with the controller port at
// 0x4016, 0x4020-0x7FFF share one byte, and ROM reads are forwarded as a
// window and offset. A write to 0x4014 flags a sprite DMA, with the stall
// length given in the stall_cycles field. ROM writes are dropped.
// ----------------------------------------------------------------------------
module console_cpu_bus_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // address[15:0], write_data[23:16], buttons[31:24]
    input  logic [ccbd_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // req_type[0]
    input  logic                                 i_s_tuser,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // read_data[7:0], graphics_reg_index[10:8], rom_bank[11], rom_offset[25:12],
    // dma_start[26], dma_page[34:27], stall_cycles[44:35], zero[47:45]
    output logic [ccbd_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // route[1:0]
    output logic [1:0]                           o_m_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready
);
    import ccbd_pkg::*;

    // Input word fields
    logic        in_we;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    logic [7:0]  in_btn;
    logic        accept;
    logic        load_out;
    logic        ram_ready;
    logic [7:0]  ram_rdata;
    t_ram_req    ram_req;

    assign in_we    = i_s_tuser;
    assign in_addr  = i_s_tdata[15:0];
    assign in_wdata = i_s_tdata[23:16];
    assign in_btn   = i_s_tdata[31:24];

    // Address decode
    logic is_ram, is_gfx, is_pad, is_io, is_rom, is_unm, is_dma;
    assign is_ram = (in_addr[15:13] == 3'b000);
    assign is_gfx = (in_addr[15:13] == 3'b001);
    assign is_pad = (in_addr == ADDR_PAD);
    assign is_io  = (in_addr[15:5] == IO_PAGE) && !is_pad;
    assign is_rom = in_addr[15];
    assign is_unm = !is_ram && !is_gfx && !is_pad && !is_io && !is_rom;
    assign is_dma = is_io && in_we && (in_addr == ADDR_DMA);

    // Local state
    logic [7:0] r_io [IO_DEPTH];
    logic [7:0] r_unm;
    logic [7:0] r_pad_shift;
    logic       r_pad_strobe;

    // Stage 1: decoded access waiting for the RAM read data
    logic              r_s1_valid;
    logic              r_s1_sel_ram;
    t_route            r_s1_route;
    logic [7:0]        r_s1_data;
    logic [2:0]        r_s1_gidx;
    logic              r_s1_bank;
    logic [13:0]       r_s1_offs;
    logic              r_s1_dma;
    logic [7:0]        r_s1_page;

    // Output register
    logic              r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [1:0]        r_m_user;

    // Handshake: stage 1 drains into the output register when it has room
    assign load_out   = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_s_tready = ram_ready && (!r_s1_valid || load_out);
    assign accept     = i_s_tvalid && o_s_tready;

    // Work RAM access at accept
    always_comb begin
        ram_req.en    = accept && is_ram;
        ram_req.we    = in_we;
        ram_req.addr  = in_addr[RAM_AW-1:0];
        ram_req.wdata = in_wdata;
    end

    ccbd_work_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata),
        .o_ready (ram_ready)
    );

    // Local read data for non-RAM reads
    logic [7:0] local_data;
    always_comb begin
        local_data = '0;
        if (!in_we) begin
            if (is_pad) begin
                local_data = PAD_OPEN_BUS | {7'd0, r_pad_shift[0]};
            end else if (is_io) begin
                local_data = r_io[in_addr[IO_AW-1:0]];
            end else if (is_unm) begin
                local_data = r_unm;
            end
        end
    end

    // I/O registers, shared byte and controller port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < IO_DEPTH; i++) begin
                r_io[i] <= '0;
            end
            r_unm        <= '0;
            r_pad_shift  <= '0;
            r_pad_strobe <= 1'b0;
        end else if (accept) begin
            if (is_io && in_we) begin
                r_io[in_addr[IO_AW-1:0]] <= in_wdata;
            end
            if (is_unm && in_we) begin
                r_unm <= in_wdata;
            end
            if (is_pad) begin
                if (in_we) begin
                    r_pad_strobe <= in_wdata[0];
                    if (in_wdata[0]) begin
                        r_pad_shift <= in_btn;
                    end
                end else if (r_pad_strobe) begin
                    r_pad_shift <= in_btn;
                end else begin
                    r_pad_shift <= {1'b0, r_pad_shift[7:1]};
                end
            end
        end
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (load_out) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sel_ram <= is_ram && !in_we;
            r_s1_data    <= local_data;
            r_s1_route   <= is_gfx ? ROUTE_GFX :
                            (is_rom && !in_we) ? ROUTE_ROM : ROUTE_LOCAL;
            r_s1_gidx    <= is_gfx ? in_addr[2:0] : 3'd0;
            r_s1_bank    <= is_rom && !in_we && in_addr[14];
            r_s1_offs    <= (is_rom && !in_we) ? in_addr[13:0] : 14'd0;
            r_s1_dma     <= is_dma;
            r_s1_page    <= is_dma ? in_wdata : 8'd0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_user <= r_s1_route;
            r_m_data <= {3'd0,
                         r_s1_dma ? DMA_STALL : 10'd0,
                         r_s1_page,
                         r_s1_dma,
                         r_s1_offs,
                         r_s1_bank,
                         r_s1_gidx,
                         r_s1_sel_ram ? ram_rdata : r_s1_data};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

>>> tb/console_cpu_bus_decoder_tb.sv
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder_tb
// Self-checking bench for the fixed-cartridge CPU bus decoder.
// ----------------------------------------------------------------------------
// Each accepted access word is decoded by a local memory-map model that keeps
// its own work RAM, I/O register, shared byte and controller images. The
// expected result goes into a queue. A monitor compares every output word
// field by field with the oldest expected result. Directed checks come first:
// RAM mirroring, graphics forwarding, I/O and DMA, controller shifting,
// the shared byte and ROM windows. A long output hold-off then fills the
// block, and random traffic follows, with bursts of idling on both sides and
// a final stretch at full rate.
// ----------------------------------------------------------------------------
module console_cpu_bus_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccbd_pkg::*;

    // Access kind on tuser
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Region boundaries of the memory map
    localparam logic [15:0] GFX_BASE    = 16'h2000;
    localparam logic [15:0] IO_BASE     = 16'h4000;
    localparam logic [15:0] SHARED_BASE = 16'h4020;
    localparam logic [15:0] ROM_BASE    = 16'h8000;
    localparam logic [15:0] ROM_HI_BASE = 16'hC000;

    localparam int HOLD_CYCLES = 200;
    localparam int MAX_PRINTS  = 40;

    // Decoded result of one access
    typedef struct packed {
        t_route      route;
        logic [7:0]  read_data;
        logic [2:0]  gfx_index;
        logic        rom_bank;
        logic [13:0] rom_offset;
        logic        dma_start;
        logic [7:0]  dma_page;
        logic [9:0]  stall_cycles;
    } t_bus_result;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tvalid;
    logic                  m_tready = 1'b0;

    // Idling and hold-off controls
    logic src_idle_en  = 1'b1;
    logic sink_idle_en = 1'b1;
    logic sink_hold    = 1'b0;
    int   sink_gap     = 0;

    // Memory map images
    logic [7:0] ram_img [RAM_DEPTH];
    logic [7:0] io_img  [IO_DEPTH];
    logic [7:0] shared_img;
    logic [7:0] pad_shift_img;
    logic       pad_strobe_img;

    t_bus_result pending_results [$];
    int          err_count = 0;

    console_cpu_bus_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Memory map decode, updates the images
    function automatic t_bus_result decode_access(input logic is_write,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] wdata,
                                                  input logic [7:0] btn);
        t_bus_result r;
        r = '0;
        if (addr < GFX_BASE) begin
            if (is_write) ram_img[addr[10:0]] = wdata;
            else          r.read_data = ram_img[addr[10:0]];
        end else if (addr < IO_BASE) begin
            r.route     = ROUTE_GFX;
            r.gfx_index = addr[2:0];
        end else if (addr == ADDR_PAD) begin
            // controller port: strobe latch and serial shift
            if (is_write) begin
                pad_strobe_img = wdata[0];
                if (wdata[0]) pad_shift_img = btn;
            end else begin
                r.read_data = PAD_OPEN_BUS | {7'd0, pad_shift_img[0]};
                if (pad_strobe_img) pad_shift_img = btn;
                else                pad_shift_img = pad_shift_img >> 1;
            end
        end else if (addr < SHARED_BASE) begin
            if (is_write) begin
                if (addr == ADDR_DMA) begin
                    r.dma_start    = 1'b1;
                    r.dma_page     = wdata;
                    r.stall_cycles = DMA_STALL;
                end
                io_img[addr[4:0]] = wdata;
            end else begin
                r.read_data = io_img[addr[4:0]];
            end
        end else if (addr < ROM_BASE) begin
            if (is_write) shared_img = wdata;
            else          r.read_data = shared_img;
        end else if (!is_write) begin
            // ROM writes are dropped, reads are forwarded
            r.route      = ROUTE_ROM;
            r.rom_bank   = (addr >= ROM_HI_BASE);
            r.rom_offset = addr[13:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Offer one access word and wait for its acceptance
    task automatic send_access(input logic is_write, input logic [15:0] addr,
                               input logic [7:0] wdata, input logic [7:0] btn);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {btn, wdata, addr};
        s_tuser  <= is_write;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(decode_access(is_write, addr, wdata, btn));
    endtask

    // Stop offering and wait until every expected word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Output ready with random stall bursts
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            sink_gap <= int'($urandom_range(0, 4));
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_bus_result got;
        t_bus_result want;
        if (rst_n && o_m_tvalid && m_tready) begin
            got.route        = t_route'(o_m_tuser);
            got.read_data    = o_m_tdata[7:0];
            got.gfx_index    = o_m_tdata[10:8];
            got.rom_bank     = o_m_tdata[11];
            got.rom_offset   = o_m_tdata[25:12];
            got.dma_start    = o_m_tdata[26];
            got.dma_page     = o_m_tdata[34:27];
            got.stall_cycles = o_m_tdata[44:35];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", int'(o_m_tdata[31:0]), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.route != want.route)
                    report_mismatch("route", got.route, want.route);
                if (got.read_data != want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.gfx_index != want.gfx_index)
                    report_mismatch("graphics_reg_index", got.gfx_index, want.gfx_index);
                if (got.rom_bank != want.rom_bank)
                    report_mismatch("rom_bank", got.rom_bank, want.rom_bank);
                if (got.rom_offset != want.rom_offset)
                    report_mismatch("rom_offset", got.rom_offset, want.rom_offset);
                if (got.dma_start != want.dma_start)
                    report_mismatch("dma_start", got.dma_start, want.dma_start);
                if (got.dma_page != want.dma_page)
                    report_mismatch("dma_page", got.dma_page, want.dma_page);
                if (got.stall_cycles != want.stall_cycles)
                    report_mismatch("stall_cycles", got.stall_cycles, want.stall_cycles);
            end
        end
    end

    // Work RAM and its mirrors
    task automatic test_ram_mirror();
        send_access(REQ_WRITE, 16'h0000, 8'hFF, 8'h00);
        send_access(REQ_READ,  16'h1800, 8'h00, 8'hFF);
        send_access(REQ_WRITE, 16'h07FF, 8'hA5, 8'h00);
        send_access(REQ_READ,  16'h1FFF, 8'h00, 8'h00);
        send_access(REQ_READ,  16'h0123, 8'hFF, 8'h00);
        drain();
    endtask

    // Graphics register forwarding
    task automatic test_graphics();
        send_access(REQ_READ,  GFX_BASE, 8'h00, 8'h00);
        send_access(REQ_WRITE, 16'h3FFF, 8'hFF, 8'hFF);
        drain();
    endtask

    // I/O registers and sprite DMA
    task automatic test_io_dma();
        send_access(REQ_WRITE, IO_BASE,  8'h5A, 8'h00);
        send_access(REQ_READ,  IO_BASE,  8'h00, 8'h00);
        send_access(REQ_READ,  16'h401F, 8'h00, 8'h00);
        send_access(REQ_WRITE, ADDR_DMA, 8'hFF, 8'h00);
        send_access(REQ_READ,  ADDR_DMA, 8'h00, 8'h00);
        send_access(REQ_WRITE, ADDR_DMA, 8'h00, 8'hFF);
        drain();
    endtask

    // Controller strobe, shift and reload
    task automatic test_pad();
        send_access(REQ_WRITE, ADDR_PAD, 8'h01, 8'hA5);
        send_access(REQ_WRITE, ADDR_PAD, 8'hFE, 8'h00);
        send_access(REQ_READ,  ADDR_PAD, 8'h00, 8'hFF);
        send_access(REQ_READ,  ADDR_PAD, 8'h00, 8'hFF);
        send_access(REQ_READ,  ADDR_PAD, 8'h00, 8'hFF);
        send_access(REQ_WRITE, ADDR_PAD, 8'hFF, 8'h3C);
        send_access(REQ_READ,  ADDR_PAD, 8'h00, 8'hFF);
        send_access(REQ_READ,  ADDR_PAD, 8'h00, 8'h01);
        drain();
    endtask

    // Shared byte and ROM windows, ROM write dropped
    task automatic test_shared_rom();
        send_access(REQ_WRITE, SHARED_BASE, 8'h77, 8'h00);
        send_access(REQ_READ,  16'h7FFF,    8'h00, 8'h00);
        send_access(REQ_READ,  ROM_BASE,    8'h00, 8'h00);
        send_access(REQ_READ,  16'hBFFF,    8'h00, 8'h00);
        send_access(REQ_READ,  ROM_HI_BASE, 8'h00, 8'h00);
        send_access(REQ_READ,  16'hFFFF,    8'hFF, 8'hFF);
        send_access(REQ_WRITE, 16'hFFFF,    8'h12, 8'h34);
        drain();
    endtask

    // Random traffic over the whole map, with controller read sequences
    task automatic test_random_traffic(input int n_items);
        int         sent;
        int         pick;
        int         n_reads;
        logic       rw;
        logic [15:0] addr;
        logic [7:0] wdata;
        logic [7:0] btn;
        sent = 0;
        while (sent < n_items) begin
            pick  = int'($urandom_range(0, 99));
            rw    = 1'($urandom_range(0, 1));
            wdata = 8'($urandom_range(0, 255));
            btn   = 8'($urandom_range(0, 255));
            if (pick < 85) begin
                if (pick < 30)      addr = 16'($urandom_range(0, 16'h1FFF));
                else if (pick < 40) addr = 16'($urandom_range(16'h2000, 16'h3FFF));
                else if (pick < 55) addr = IO_BASE + 16'($urandom_range(0, 31));
                else if (pick < 60) begin
                    addr = ADDR_DMA;
                    rw   = REQ_WRITE;
                end
                else if (pick < 70) addr = 16'($urandom_range(16'h4020, 16'h7FFF));
                else                addr = 16'($urandom_range(16'h8000, 16'hFFFF));
                send_access(rw, addr, wdata, btn);
                sent++;
            end else if (pick < 95) begin
                // strobe high, strobe low, then read the bits out
                send_access(REQ_WRITE, ADDR_PAD, wdata | 8'h01, btn);
                wdata = 8'($urandom_range(0, 255));
                send_access(REQ_WRITE, ADDR_PAD, wdata & 8'hFE, 8'($urandom_range(0, 255)));
                n_reads = int'($urandom_range(1, 9));
                repeat (n_reads)
                    send_access(REQ_READ, ADDR_PAD, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                sent += n_reads + 2;
            end else begin
                send_access(rw, 16'($urandom_range(0, 16'hFFFF)), wdata, btn);
                sent++;
            end
        end
        drain();
    endtask

    // Receiver holds off while accesses keep coming, so the input stalls
    task automatic test_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            test_random_traffic(40);
        join
    endtask

    // Test sequence
    initial begin
        foreach (ram_img[i]) ram_img[i] = '0;
        foreach (io_img[i])  io_img[i]  = '0;
        shared_img     = '0;
        pad_shift_img  = '0;
        pad_strobe_img = 1'b0;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        test_ram_mirror();
        test_graphics();
        test_io_dma();
        test_pad();
        test_shared_rom();
        test_backpressure();
        test_random_traffic(1000);

        // full rate for the last part
        src_idle_en  <= 1'b0;
        sink_idle_en <= 1'b0;
        @(posedge i_clk);
        test_random_traffic(250);

        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), 0);
        if (err_count == 0) begin
            $display("** console_cpu_bus_decoder: PASSED **");
        end else begin
            $display("** console_cpu_bus_decoder: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("** console_cpu_bus_decoder: FAILED **");
        $finish;
    end

endmodule
